/* hw/rtl/uvs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers of the UV sphere tessellator.
package uvs_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int MAX_RINGS    = 256;
  localparam int FRAC_BITS    = 14;

  // pi in Q30, used to turn a quarter-turn binary angle into radians
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  localparam logic [8:0] CNT_RESET = 9'd16;

  // Divider: four quotient bits per stage, eight stages
  localparam int DIV_LAT  = 8;
  // Sine/cosine: angle scale, square, two stages per series term, clamp
  localparam int SC_STEPS = 7;
  localparam int SC_LAT   = 2 * SC_STEPS + 3;

  // Index results that follow the vertex of a quad
  localparam logic [2:0] IDX_BEATS = 3'd6;

  typedef enum logic [1:0] {
    KIND_VTX = 2'd0,
    KIND_IDX = 2'd1,
    KIND_REJ = 2'd2
  } kind_t;

  typedef enum logic {
    REG_SEGMENTS = 1'b0,
    REG_RINGS    = 1'b1
  } reg_idx_t;

  // Per-item side information carried beside the arithmetic
  typedef struct packed {
    logic        rej;
    logic        quad;
    logic [16:0] cur;
    logic [16:0] nxt;
    logic [14:0] tex_u;
    logic [14:0] tex_v;
  } meta_t;

  // Finished vertex record handed to the output stage
  typedef struct packed {
    logic               rej;
    logic               quad;
    logic signed [14:0] pos_x;
    logic signed [14:0] pos_y;
    logic signed [14:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic [16:0]        cur;
    logic [16:0]        nxt;
  } res_t;

  // Shift right by sh, rounding half away from zero on the magnitude
  function automatic logic signed [63:0] round_away(input logic signed [63:0] v,
                                                    input int sh);
    logic [63:0] mag;
    logic [63:0] rnd;
    mag = v[63] ? 64'(-v) : 64'(v);
    rnd = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(rnd) : $signed(rnd);
  endfunction

endpackage

/* hw/rtl/uvs_div.sv */
`timescale 1ns / 1ps
// Pipelined long division producing the two angles and the texture coordinates.
module uvs_div (
  input  logic        clk,
  input  logic        en,
  input  logic [8:0]  col,
  input  logic [8:0]  row,
  input  logic [8:0]  seg,
  input  logic [8:0]  rng,
  output logic [31:0] theta,
  output logic [31:0] phi,
  output logic [14:0] tex_u,
  output logic [14:0] tex_v
);

  localparam int LANES    = 4;
  localparam int STEP_PER = 4;

  // Fraction bits produced by each lane: theta, phi, tex_u, tex_v
  function automatic int lane_bits(input int l);
    int k;
    k = uvs_pkg::FRAC_BITS;
    if (l == 0) k = 32;
    else if (l == 1) k = 31;
    return k;
  endfunction

  logic [8:0]  hi_in [LANES];
  logic [8:0]  d_in  [LANES];

  logic [9:0]  r_q    [uvs_pkg::DIV_LAT][LANES];
  logic [32:0] q_q    [uvs_pkg::DIV_LAT][LANES];
  logic [8:0]  d_q    [uvs_pkg::DIV_LAT][LANES];
  logic [9:0]  r_next [uvs_pkg::DIV_LAT][LANES];
  logic [32:0] q_next [uvs_pkg::DIV_LAT][LANES];
  logic [8:0]  d_next [uvs_pkg::DIV_LAT][LANES];

  assign hi_in = '{col, row, col, row};
  assign d_in  = '{seg, rng, seg, rng};

  // Restoring division: numerator is hi * 2^K + floor(d / 2)
  always_comb begin
    logic [10:0] t;
    logic [9:0]  r;
    logic [32:0] q;
    logic [8:0]  d;
    logic [7:0]  h;
    logic        qb;
    int          bp;
    for (int s = 0; s < uvs_pkg::DIV_LAT; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          d = d_in[l];
          r = 10'(hi_in[l]);
          q = '0;
          if (r >= 10'(d)) begin
            r = r - 10'(d);
            q = 33'd1;
          end
        end else begin
          d = d_q[(s == 0) ? 0 : s - 1][l];
          r = r_q[(s == 0) ? 0 : s - 1][l];
          q = q_q[(s == 0) ? 0 : s - 1][l];
        end
        h = d[8:1];
        for (int j = 0; j < STEP_PER; j++) begin
          bp = lane_bits(l) - 1 - (STEP_PER * s + j);
          if (bp >= 0) begin
            t = {r, 1'b0};
            if (bp < 8) t[0] = h[3'(bp)];
            qb = (t >= 11'(d));
            if (qb) t = t - 11'(d);
            r = t[9:0];
            q = {q[31:0], qb};
          end
        end
        r_next[s][l] = r;
        q_next[s][l] = q;
        d_next[s][l] = d;
      end
    end
  end

  // Advance all division stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < uvs_pkg::DIV_LAT; s++) begin
        for (int l = 0; l < LANES; l++) begin
          r_q[s][l] <= r_next[s][l];
          q_q[s][l] <= q_next[s][l];
          d_q[s][l] <= d_next[s][l];
        end
      end
    end
  end

  assign theta = q_q[uvs_pkg::DIV_LAT-1][0][31:0];
  assign phi   = q_q[uvs_pkg::DIV_LAT-1][1][31:0];
  assign tex_u = q_q[uvs_pkg::DIV_LAT-1][2][14:0];
  assign tex_v = q_q[uvs_pkg::DIV_LAT-1][3][14:0];

endmodule

/* hw/rtl/uvs_sincos.sv */
`timescale 1ns / 1ps
// Pipelined Q30 sine and cosine of a 32-bit binary angle by Taylor series.
module uvs_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        ang,
  output logic signed [31:0] sin_val,
  output logic signed [31:0] cos_val
);

  localparam int N = uvs_pkg::SC_STEPS;

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [31:0] res;
    res = 32'(v);
    if (v < 0) res = '0;
    else if (v > uvs_pkg::ONE_Q30) res = 32'(uvs_pkg::ONE_Q30);
    return res;
  endfunction

  logic [30:0] x1;
  logic [1:0]  qd1;

  // Per term registers; index 0 holds the series start
  logic [30:0]        ts    [N+1];
  logic [30:0]        tc    [N+1];
  logic signed [33:0] s_acc [N+1];
  logic signed [33:0] c_acc [N+1];
  logic [31:0]        x2    [N+1];
  logic [1:0]         qd    [N+1];

  // Product stage registers of each term
  logic [32:0]        ps    [1:N];
  logic [32:0]        pc    [1:N];
  logic signed [33:0] sa    [1:N];
  logic signed [33:0] ca    [1:N];
  logic [31:0]        xa    [1:N];
  logic [1:0]         qa    [1:N];

  logic [30:0]        ts_n  [1:N];
  logic [30:0]        tc_n  [1:N];

  logic signed [31:0] s_cl;
  logic signed [31:0] c_cl;

  // Divide each term by its series divisor via a reciprocal multiply
  for (genvar k = 1; k <= N; k++) begin : g_term
    localparam longint unsigned DS = 64'(2 * k * (2 * k + 1));
    localparam longint unsigned DC = 64'((2 * k - 1) * (2 * k));
    localparam int KS = 33 + $clog2(DS);
    localparam int KC = 33 + $clog2(DC);
    localparam logic [33:0] MS = 34'(((64'd1 << KS) + DS - 1) / DS);
    localparam logic [33:0] MC = 34'(((64'd1 << KC) + DC - 1) / DC);
    assign ts_n[k] = 31'((67'(ps[k]) * 67'(MS)) >> KS);
    assign tc_n[k] = 31'((67'(pc[k]) * 67'(MC)) >> KC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Scale the quarter-turn fraction to radians
      x1  <= 31'((62'(ang[29:0]) * 62'(uvs_pkg::PI_Q30)) >> 31);
      qd1 <= ang[31:30];
      // Square and seed both series
      x2[0]    <= 32'((62'(x1) * 62'(x1)) >> 30);
      ts[0]    <= x1;
      tc[0]    <= 31'(uvs_pkg::ONE_Q30);
      s_acc[0] <= 34'(x1);
      c_acc[0] <= uvs_pkg::ONE_Q30;
      qd[0]    <= qd1;
      for (int k = 1; k <= N; k++) begin
        // Multiply the previous term by x squared
        ps[k] <= 33'((63'(ts[k-1]) * 63'(x2[k-1])) >> 30);
        pc[k] <= 33'((63'(tc[k-1]) * 63'(x2[k-1])) >> 30);
        sa[k] <= s_acc[k-1];
        ca[k] <= c_acc[k-1];
        xa[k] <= x2[k-1];
        qa[k] <= qd[k-1];
        // Accumulate the divided term with alternating sign
        ts[k] <= ts_n[k];
        tc[k] <= tc_n[k];
        if (k % 2 == 1) begin
          s_acc[k] <= sa[k] - 34'(ts_n[k]);
          c_acc[k] <= ca[k] - 34'(tc_n[k]);
        end else begin
          s_acc[k] <= sa[k] + 34'(ts_n[k]);
          c_acc[k] <= ca[k] + 34'(tc_n[k]);
        end
        x2[k] <= xa[k];
        qd[k] <= qa[k];
      end
      // Clamp and fold into the quadrant
      unique case (qd[N])
        2'd0: begin
          sin_val <= s_cl;
          cos_val <= c_cl;
        end
        2'd1: begin
          sin_val <= c_cl;
          cos_val <= -s_cl;
        end
        2'd2: begin
          sin_val <= -s_cl;
          cos_val <= -c_cl;
        end
        default: begin
          sin_val <= -c_cl;
          cos_val <= s_cl;
        end
      endcase
    end
  end

  assign s_cl = clamp_q30(s_acc[N]);
  assign c_cl = clamp_q30(c_acc[N]);

endmodule

/* hw/rtl/uvs_emit.sv */
`timescale 1ns / 1ps
// Output stage: holds one vertex record and sends its results one per request.
module uvs_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          ld_valid,
  input  uvs_pkg::res_t ld_rec,
  output logic          ld_ready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                       // tex_u, tex_v, vertex_index, zero fill
  output logic [1:0]    m_axis_tuser,  // kind
  output logic          m_axis_tlast
);

  logic          full;
  logic [2:0]    cnt;
  uvs_pkg::res_t rec;

  uvs_pkg::kind_t     kind;
  logic               last;
  logic [16:0]        vidx;
  logic signed [14:0] px, py, pz;
  logic signed [15:0] nx, ny, nz;
  logic [14:0]        tu, tv;

  // Select the fields of the current result
  always_comb begin
    kind = uvs_pkg::KIND_VTX;
    last = 1'b0;
    vidx = '0;
    px = '0; py = '0; pz = '0;
    nx = '0; ny = '0; nz = '0;
    tu = '0; tv = '0;
    if (cnt == '0) begin
      if (rec.rej) begin
        kind = uvs_pkg::KIND_REJ;
        last = 1'b1;
      end else begin
        kind = uvs_pkg::KIND_VTX;
        last = !rec.quad;
        px = rec.pos_x;  py = rec.pos_y;  pz = rec.pos_z;
        nx = rec.norm_x; ny = rec.norm_y; nz = rec.norm_z;
        tu = rec.tex_u;  tv = rec.tex_v;
      end
    end else begin
      kind = uvs_pkg::KIND_IDX;
      last = (cnt == uvs_pkg::IDX_BEATS);
      unique case (cnt)
        3'd1:       vidx = rec.cur;
        3'd2:       vidx = rec.nxt;
        3'd3, 3'd4: vidx = rec.cur + 17'd1;
        3'd5:       vidx = rec.nxt;
        default:    vidx = rec.nxt + 17'd1;
      endcase
    end
  end

  assign ld_ready      = !full || (m_axis_tready && last);
  assign m_axis_tvalid = full;
  assign m_axis_tuser  = kind;
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {4'd0, vidx, tv, tu, nz, ny, nx, pz, py, px};

  // Load a new record or step through the results of the held one
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      cnt  <= '0;
    end else if (ld_valid && ld_ready) begin
      full <= 1'b1;
      cnt  <= '0;
    end else if (full && m_axis_tready) begin
      if (last) full <= 1'b0;
      else cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid && ld_ready) rec <= ld_rec;
  end

endmodule

/* hw/rtl/uv_sphere_tessellator_top.sv */
`timescale 1ns / 1ps
// Stages: input register, 8 divider stages, 17 sine/cosine stages, product, rounding,
// output holding register.
// Throughput: one grid point per cycle while the tail is not held; the output sends one
// result per ready cycle: seven for a quad point, one for an edge or rejected point.
// Reset clears all valid bits and the output stage and sets both counts to 16.
module uv_sphere_tessellator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // row, column, zero fill
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                       // tex_u, tex_v, vertex_index, zero fill
  output logic [1:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int DL = uvs_pkg::DIV_LAT;
  localparam int SL = uvs_pkg::SC_LAT;

  logic [8:0] seg_cfg;
  logic [8:0] rng_cfg;

  logic en;
  logic ld_ready;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = 32'(paddr[2] == uvs_pkg::REG_RINGS ? rng_cfg : seg_cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cfg <= uvs_pkg::CNT_RESET;
      rng_cfg <= uvs_pkg::CNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == uvs_pkg::REG_RINGS) rng_cfg <= pwdata[8:0];
      else seg_cfg <= pwdata[8:0];
    end
  end

  // Front end: clamp counts, classify the point, form the quad corner indices
  logic [8:0]  in_row, in_col, seg_eff, rng_eff;
  logic [16:0] in_cur;
  uvs_pkg::meta_t in_meta;

  assign in_row  = s_axis_tdata[8:0];
  assign in_col  = s_axis_tdata[17:9];
  assign seg_eff = (11'(seg_cfg) > 11'(uvs_pkg::MAX_SEGMENTS)) ?
                   9'(uvs_pkg::MAX_SEGMENTS) : seg_cfg;
  assign rng_eff = (11'(rng_cfg) > 11'(uvs_pkg::MAX_RINGS)) ?
                   9'(uvs_pkg::MAX_RINGS) : rng_cfg;
  assign in_cur  = 17'(17'(in_row) * (17'(seg_eff) + 17'd1)) + 17'(in_col);

  always_comb begin
    in_meta       = '0;
    in_meta.rej   = (seg_eff == '0) || (rng_eff == '0) ||
                    (in_row > rng_eff) || (in_col > seg_eff);
    in_meta.quad  = (in_row < rng_eff) && (in_col < seg_eff);
    in_meta.cur   = in_cur;
    in_meta.nxt   = in_cur + 17'(seg_eff) + 17'd1;
  end

  logic           f_vld;
  logic [8:0]     f_row, f_col, f_seg, f_rng;
  uvs_pkg::meta_t f_meta;

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (en) f_vld <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_row  <= in_row;
      f_col  <= in_col;
      f_seg  <= seg_eff;
      f_rng  <= rng_eff;
      f_meta <= in_meta;
    end
  end

  // Angles and texture coordinates
  logic [31:0] theta, phi;
  logic [14:0] tex_u, tex_v;

  uvs_div u_div (
    .clk   (clk),
    .en    (en),
    .col   (f_col),
    .row   (f_row),
    .seg   (f_seg),
    .rng   (f_rng),
    .theta (theta),
    .phi   (phi),
    .tex_u (tex_u),
    .tex_v (tex_v)
  );

  logic           vd [DL];
  uvs_pkg::meta_t md [DL];
  uvs_pkg::meta_t mt;

  always_comb begin
    mt       = md[DL-1];
    mt.tex_u = tex_u;
    mt.tex_v = tex_v;
  end

  // Sine and cosine of both angles
  logic signed [31:0] sp, cp, st, ct;

  uvs_sincos u_sc_phi (
    .clk     (clk),
    .en      (en),
    .ang     (phi),
    .sin_val (sp),
    .cos_val (cp)
  );

  uvs_sincos u_sc_theta (
    .clk     (clk),
    .en      (en),
    .ang     (theta),
    .sin_val (st),
    .cos_val (ct)
  );

  logic           vs [SL];
  uvs_pkg::meta_t ms [SL];

  // Products, then rounding into the record
  logic               p_vld;
  uvs_pkg::meta_t     p_meta;
  logic signed [63:0] p_xc, p_zs;
  logic signed [31:0] p_cp;

  logic               r_vld;
  uvs_pkg::res_t      r_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) vd[i] <= 1'b0;
      for (int i = 0; i < SL; i++) vs[i] <= 1'b0;
      p_vld <= 1'b0;
      r_vld <= 1'b0;
    end else if (en) begin
      vd[0] <= f_vld;
      for (int i = 1; i < DL; i++) vd[i] <= vd[i-1];
      vs[0] <= vd[DL-1];
      for (int i = 1; i < SL; i++) vs[i] <= vs[i-1];
      p_vld <= vs[SL-1];
      r_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md[0] <= f_meta;
      for (int i = 1; i < DL; i++) md[i] <= md[i-1];
      ms[0] <= mt;
      for (int i = 1; i < SL; i++) ms[i] <= ms[i-1];
      p_meta <= ms[SL-1];
      p_xc   <= 64'(sp) * 64'(ct);
      p_zs   <= 64'(sp) * 64'(st);
      p_cp   <= cp;
      r_rec.rej    <= p_meta.rej;
      r_rec.quad   <= p_meta.quad;
      r_rec.pos_x  <= 15'(uvs_pkg::round_away(p_xc, 61 - uvs_pkg::FRAC_BITS));
      r_rec.pos_y  <= 15'(uvs_pkg::round_away(64'(p_cp), 31 - uvs_pkg::FRAC_BITS));
      r_rec.pos_z  <= 15'(uvs_pkg::round_away(p_zs, 61 - uvs_pkg::FRAC_BITS));
      r_rec.norm_x <= 16'(uvs_pkg::round_away(p_xc, 60 - uvs_pkg::FRAC_BITS));
      r_rec.norm_y <= 16'(uvs_pkg::round_away(64'(p_cp), 30 - uvs_pkg::FRAC_BITS));
      r_rec.norm_z <= 16'(uvs_pkg::round_away(p_zs, 60 - uvs_pkg::FRAC_BITS));
      r_rec.tex_u  <= p_meta.tex_u;
      r_rec.tex_v  <= p_meta.tex_v;
      r_rec.cur    <= p_meta.cur;
      r_rec.nxt    <= p_meta.nxt;
    end
  end

  // Hold the whole pipeline while the output stage cannot take the tail
  assign en            = !r_vld || ld_ready;
  assign s_axis_tready = en;

  uvs_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .ld_valid      (r_vld),
    .ld_rec        (r_rec),
    .ld_ready      (ld_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A rejected point is always a single result
  a_rej_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == uvs_pkg::KIND_REJ |-> m_axis_tlast)
    else $error("rejected result without last");

  // An empty pipeline tail never blocks new requests
  a_tail_free: assert property (@(posedge clk) disable iff (rst)
    !r_vld |-> s_axis_tready)
    else $error("input stalled with empty pipeline tail");

  // A quad vertex is followed at once by its index results
  a_vtx_then_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == uvs_pkg::KIND_VTX && !m_axis_tlast
    |=> m_axis_tvalid && m_axis_tuser == uvs_pkg::KIND_IDX)
    else $error("index results missing after quad vertex");

endmodule

/* verif/uv_sphere_tessellator_checker.sv */
`timescale 1ns / 1ps
// Checker of the UV sphere tessellator: watches the streams and the APB port, predicts results.
module uv_sphere_tessellator_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [143:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           pending,
  output int           fail_count
);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [14:0] pos_x;
    logic signed [14:0] pos_y;
    logic signed [14:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [14:0]        tex_u;
    logic [14:0]        tex_v;
    logic [16:0]        vertex_index;
    logic               last;
  } sphere_res_t;

  sphere_res_t expected_results[$];
  logic [8:0]  segments_reg;
  logic [8:0]  rings_reg;

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Append one expected result at the tail
  task automatic queue_result(input sphere_res_t r);
    expected_results = {expected_results, r};
  endtask

  // Rounded shift, half away from zero on the magnitude
  function automatic longint shift_round(input longint v, input int sh);
    bit [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // Sine and cosine of a binary angle in Q30
  function automatic void sin_cos(input bit [31:0] ang, output longint s_o, output longint c_o);
    bit [63:0] f, x, x2, ts, tc;
    longint    s, c;
    f  = {34'd0, ang[29:0]};
    x  = (f * 64'(uvs_pkg::PI_Q30)) >> 31;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    s  = longint'(x);
    c  = longint'(tc);
    for (int k = 1; k < 8; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        s -= longint'(ts);
        c -= longint'(tc);
      end else begin
        s += longint'(ts);
        c += longint'(tc);
      end
    end
    if (s < 0) s = 0;
    if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
    if (c < 0) c = 0;
    if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
    case (ang[31:30])
      2'd0:    begin s_o = s;  c_o = c;  end
      2'd1:    begin s_o = c;  c_o = -s; end
      2'd2:    begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s;  end
    endcase
  endfunction

  // Work out the results of one grid point
  task automatic predict_point(input bit [8:0] row, input bit [8:0] col);
    bit [63:0]   seg, rng, num, cur, nxt;
    bit [31:0]   theta, phi;
    longint      sp, cp, st, ct;
    bit          quad;
    sphere_res_t r;
    seg = (segments_reg > uvs_pkg::MAX_SEGMENTS) ?
          64'(uvs_pkg::MAX_SEGMENTS) : 64'(segments_reg);
    rng = (rings_reg > uvs_pkg::MAX_RINGS) ? 64'(uvs_pkg::MAX_RINGS) : 64'(rings_reg);
    r = '0;
    if (seg == 0 || rng == 0 || row > rng || col > seg) begin
      r.kind = uvs_pkg::KIND_REJ;
      r.last = 1'b1;
      queue_result(r);
      return;
    end
    num   = (64'(col) << 32) + seg / 2;
    theta = 32'(num / seg);
    num   = (64'(row) << 31) + rng / 2;
    phi   = 32'(num / rng);
    sin_cos(phi, sp, cp);
    sin_cos(theta, st, ct);
    quad = (row < rng) && (col < seg);
    r.kind   = uvs_pkg::KIND_VTX;
    r.pos_x  = 15'(shift_round(sp * ct, 61 - uvs_pkg::FRAC_BITS));
    r.pos_y  = 15'(shift_round(cp, 31 - uvs_pkg::FRAC_BITS));
    r.pos_z  = 15'(shift_round(sp * st, 61 - uvs_pkg::FRAC_BITS));
    r.norm_x = 16'(shift_round(sp * ct, 60 - uvs_pkg::FRAC_BITS));
    r.norm_y = 16'(shift_round(cp, 30 - uvs_pkg::FRAC_BITS));
    r.norm_z = 16'(shift_round(sp * st, 60 - uvs_pkg::FRAC_BITS));
    r.tex_u  = 15'(((64'(col) << uvs_pkg::FRAC_BITS) + seg / 2) / seg);
    r.tex_v  = 15'(((64'(row) << uvs_pkg::FRAC_BITS) + rng / 2) / rng);
    r.last   = !quad;
    queue_result(r);
    if (quad) begin
      cur = 64'(row) * (seg + 1) + 64'(col);
      nxt = cur + seg + 1;
      r = '0;
      r.kind = uvs_pkg::KIND_IDX;
      for (int i = 0; i < 6; i++) begin
        case (i)
          0:       r.vertex_index = 17'(cur);
          1, 4:    r.vertex_index = 17'(nxt);
          2, 3:    r.vertex_index = 17'(cur + 1);
          default: r.vertex_index = 17'(nxt + 1);
        endcase
        r.last = (i == 5);
        queue_result(r);
      end
    end
  endtask

  // Follow register writes, predict on each request, compare each result
  always @(posedge clk) begin
    sphere_res_t want;
    if (rst) begin
      segments_reg <= uvs_pkg::CNT_RESET;
      rings_reg    <= uvs_pkg::CNT_RESET;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(4 * uvs_pkg::REG_SEGMENTS)) segments_reg <= pwdata[8:0];
        else if (paddr == 3'(4 * uvs_pkg::REG_RINGS)) rings_reg <= pwdata[8:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_point(s_axis_tdata[8:0], s_axis_tdata[17:9]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser != want.kind) report("kind", m_axis_tuser, want.kind);
          if ($signed(m_axis_tdata[14:0]) != want.pos_x)
            report("pos_x", $signed(m_axis_tdata[14:0]), want.pos_x);
          if ($signed(m_axis_tdata[29:15]) != want.pos_y)
            report("pos_y", $signed(m_axis_tdata[29:15]), want.pos_y);
          if ($signed(m_axis_tdata[44:30]) != want.pos_z)
            report("pos_z", $signed(m_axis_tdata[44:30]), want.pos_z);
          if ($signed(m_axis_tdata[60:45]) != want.norm_x)
            report("norm_x", $signed(m_axis_tdata[60:45]), want.norm_x);
          if ($signed(m_axis_tdata[76:61]) != want.norm_y)
            report("norm_y", $signed(m_axis_tdata[76:61]), want.norm_y);
          if ($signed(m_axis_tdata[92:77]) != want.norm_z)
            report("norm_z", $signed(m_axis_tdata[92:77]), want.norm_z);
          if (m_axis_tdata[107:93] != want.tex_u)
            report("tex_u", m_axis_tdata[107:93], want.tex_u);
          if (m_axis_tdata[122:108] != want.tex_v)
            report("tex_v", m_axis_tdata[122:108], want.tex_v);
          if (m_axis_tdata[139:123] != want.vertex_index)
            report("vertex_index", m_axis_tdata[139:123], want.vertex_index);
          if (m_axis_tdata[143:140] != 4'd0)
            report("fill", m_axis_tdata[143:140], 0);
          if (m_axis_tlast != want.last) report("last", m_axis_tlast, want.last);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* verif/uv_sphere_tessellator_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top of the UV sphere tessellator: clock, reset, stimulus and verdict.
module uv_sphere_tessellator_top_tb;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata;   // row, column, zero fill
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                                // tex_u, tex_v, vertex_index, zero fill
  logic [1:0]   m_axis_tuser;   // kind
  logic         m_axis_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int   pending;
  int   fail_count;
  logic result_taken;
  bit   no_idle;
  int   quiet_cycles;
  int   seg_now;
  int   rng_now;

  uv_sphere_tessellator_top DUT (.*);

  uv_sphere_tessellator_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Note each result request for the receiver, count quiet cycles for the watchdog
  always @(posedge clk) begin
    result_taken <= m_axis_tvalid && m_axis_tready;
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (quiet_cycles >= 3000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: after each taken result, may drop ready for a random wait unless no_idle is set
  initial begin
    int wait_left;
    m_axis_tready = 1'b0;
    wait_left = $urandom_range(0, 6);
    forever begin
      @(negedge clk);
      if (m_axis_tready) begin
        if (result_taken && !no_idle) begin
          wait_left = $urandom_range(0, 6);
          if (wait_left > 0) m_axis_tready <= 1'b0;
        end
      end else if (wait_left <= 1 || no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        wait_left--;
      end
    end
  end

  task automatic reg_write(input uvs_pkg::reg_idx_t idx, input int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * idx);
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Send one grid point after a random gap unless no_idle is set, advance once it is taken
  task automatic send_point(input int row, input int col);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, 9'(col), 9'(row)};
    #1;
    while (!s_axis_tready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  // Drain every expected result, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic int clip(input int v, input int hi);
    return (v > hi) ? hi : v;
  endfunction

  initial begin
    int seg_list[9] = '{16, 1, 256, 0, 5, 300, 3, 9, 255};
    int rng_list[9] = '{16, 1, 256, 7, 0, 511, 2, 13, 256};
    int row_d[14] = '{0, 16, 16, 0, 15, 17, 0, 511, 8, 4, 3, 16, 256, 1};
    int col_d[14] = '{0, 16, 0, 16, 15, 0, 17, 511, 4, 8, 3, 15, 2, 256};
    int r_hi;
    int c_hi;
    rst           = 1'b1;
    no_idle       = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed corners with the reset counts
    foreach (row_d[i]) send_point(row_d[i], col_d[i]);
    drain();

    for (int p = 0; p < 9; p++) begin
      if (p > 0) begin
        reg_write(uvs_pkg::REG_SEGMENTS, seg_list[p]);
        reg_write(uvs_pkg::REG_RINGS, rng_list[p]);
      end
      seg_now = clip(seg_list[p] % 512, uvs_pkg::MAX_SEGMENTS);
      rng_now = clip(rng_list[p] % 512, uvs_pkg::MAX_RINGS);
      no_idle = (p % 3 == 1);
      r_hi = (rng_now == 0) ? 3 : rng_now;
      c_hi = (seg_now == 0) ? 3 : seg_now;
      for (int n = 0; n < 38; n++) begin
        if ($urandom_range(0, 4) == 0)
          send_point($urandom_range(0, 511), $urandom_range(0, 511));
        else
          send_point($urandom_range(0, r_hi), $urandom_range(0, c_hi));
      end
      drain();
    end
    no_idle = 1'b0;

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* uv_sphere_tessellator_top.f */
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_div.sv
hw/rtl/uvs_sincos.sv
hw/rtl/uvs_emit.sv
hw/rtl/uv_sphere_tessellator_top.sv
verif/uv_sphere_tessellator_checker.sv
verif/uv_sphere_tessellator_top_tb.sv
